FILE: hdl/plsc_pkg.sv
// plsc_pkg: shared constants and types for the l1 prox with sum constraint core
// no dependencies
`default_nettype none
package plsc_pkg;
    localparam int MAX_ELEMENTS_DEF  = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int SAMPLE_W = 32;
    localparam int LAMBDA_W = 31;
    localparam int BP_W     = 33;
    localparam int ACC_W    = 48;
    localparam int IDX_W    = 1;

    localparam logic [IDX_W-1:0] REG_THRESHOLD  = 1'b0;
    localparam logic [IDX_W-1:0] REG_TARGET_SUM = 1'b1;

    localparam logic [31:0] THRESHOLD_RST = 32'd65536;

    typedef struct packed {
        logic start;
        logic neg;
    } div_ctrl_t;
endpackage
`default_nettype wire

FILE: hdl/plsc_div.sv
// plsc_div: restoring divider, one quotient bit per cycle, rounds half away from zero
// depends on plsc_pkg
`default_nettype none
module plsc_div
    import plsc_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_ctrl_t         ctrl,
    input  wire logic [ACC_W-1:0]  mag,
    input  wire logic [CNT_W-1:0]  divisor,
    output logic                   done,
    output logic signed [ACC_W:0]  quot
);
    localparam int STEPS_W = $clog2(ACC_W + 1);
    logic [ACC_W-1:0]   q_reg, q_next;
    logic [CNT_W:0]     r_reg, r_next;
    logic [STEPS_W-1:0] n_reg, n_next;
    logic               busy_reg, busy_next, neg_reg, neg_next, done_next;
    logic [CNT_W:0]     trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; n_next = n_reg;
        busy_next = busy_reg; neg_next = neg_reg; done_next = 1'b0;
        trial = {r_reg[CNT_W-1:0], q_reg[ACC_W-1]};
        if (ctrl.start) begin
            // add half the divisor for rounding
            q_next = mag + ACC_W'(divisor >> 1);
            r_next = '0;
            n_next = STEPS_W'(ACC_W);
            busy_next = 1'b1;
            neg_next = ctrl.neg;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[ACC_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[ACC_W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == STEPS_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next; r_reg <= r_next; n_reg <= n_next; neg_reg <= neg_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done     <= done_next;
        end
    end

    assign quot = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule
`default_nettype wire

FILE: hdl/prox_l1_with_sum_constraint_core.sv
// prox l1 with sum constraint core: load, sort, bisect, solve, emit
// the loaded vector passes through breakpoint, sort, bisection, support and divider steps,
// then n output items are emitted, each held while m_ready is low; one vector in flight at a time
// reset (aresetn, synchronous) clears counts and marks, sets the threshold to its reset value and the
// target sum to zero; stores are unset until loaded; depends on plsc_pkg, plsc_div
`default_nettype none
module prox_l1_with_sum_constraint_core
    import plsc_pkg::*;
#(
    parameter int MAX_ELEMENTS  = MAX_ELEMENTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [IDX_W-1:0]           cfg_index,
    input  wire logic [31:0]                cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_sample,
    input  wire logic                       s_excluded,
    input  wire logic                       s_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_value,
    output logic                            m_empty_support,
    output logic                            m_final_res
);
    localparam int NB    = 2 * MAX_ELEMENTS;
    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int BW    = $clog2(NB);
    localparam int CW    = AW + 1;
    localparam int MW    = BW + 1;
    localparam int ITW   = $clog2(BW + 2);
    localparam logic signed [BP_W+1:0] WIDEN = (BP_W+2)'(10) <<< FRACTION_BITS;

    localparam logic [3:0] ST_LOAD = 4'd0, ST_BPRD = 4'd1, ST_BPWR = 4'd2,
                           ST_SRT0 = 4'd3, ST_SRT1 = 4'd4, ST_SRT2 = 4'd5,
                           ST_BIS0 = 4'd6, ST_BIS1 = 4'd7, ST_BIS2 = 4'd8,
                           ST_SUP0 = 4'd9, ST_SUP1 = 4'd10, ST_SUP2 = 4'd11,
                           ST_DIV  = 4'd12, ST_OUT = 4'd13, ST_OUTW = 4'd14;

    logic [3:0] st_reg;
    logic signed [SAMPLE_W-1:0] smem [MAX_ELEMENTS];
    logic signed [BP_W-1:0]     bmem [NB];
    logic signed [SAMPLE_W-1:0] srd_reg;
    logic signed [BP_W-1:0]     brd_reg;
    logic [LAMBDA_W-1:0] lam_reg;
    logic signed [31:0]  b_reg;
    logic [CW-1:0] cnt_reg, i_reg;
    logic [AW-1:0] excl_pos_reg;
    logic          excl_vld_reg;
    logic [MW-1:0] m_reg, si_reg, sj_reg;
    logic signed [BP_W-1:0] key_reg, a_reg, lo_v_reg;
    logic signed [MW:0] lo_reg, hi_reg;
    logic [ITW-1:0] its_reg;
    logic signed [ACC_W-1:0] h_reg, sum_reg;
    logic [CW-1:0] sc_reg;
    logic signed [BP_W+1:0] a2_reg;
    logic empty_reg, phase_reg;
    logic signed [ACC_W:0] nu_reg;

    // shared memory address and write
    logic [AW-1:0] s_raddr;
    logic [BW-1:0] b_raddr, b_waddr;
    logic          b_we;
    logic signed [BP_W-1:0] b_wdata;

    wire lam_s = 1'b0;
    wire signed [ACC_W-1:0] lam_x = $signed({{(ACC_W-LAMBDA_W){lam_s}}, lam_reg});
    wire signed [ACC_W-1:0] x_x   = ACC_W'(srd_reg);
    wire signed [ACC_W-1:0] d_x   = x_x - ACC_W'(a_reg);
    wire cur_excl = excl_vld_reg && (i_reg[AW-1:0] == excl_pos_reg)
                    && (i_reg != CW'(0) || 1'b1);
    // one shared soft-threshold unit
    logic signed [ACC_W-1:0] soft_in, soft_out;
    always_comb begin
        if (soft_in > lam_x) soft_out = soft_in - lam_x;
        else if (soft_in < -lam_x) soft_out = soft_in + lam_x;
        else soft_out = '0;
    end

    div_ctrl_t dctl;
    logic      ddone;
    logic signed [ACC_W:0] dq;
    logic signed [ACC_W-1:0] num;
    assign num = sum_reg - ACC_W'(b_reg);

    plsc_div #(.CNT_W(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctrl(dctl),
        .mag(num < 0 ? -num : num), .divisor(sc_reg),
        .done(ddone), .quot(dq)
    );

    assign s_ready   = (st_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    wire s_acc = s_valid && s_ready;
    wire fin   = s_last || (cnt_reg == CW'(MAX_ELEMENTS - 1));
    wire [CW-1:0] n_w = cnt_reg;
    wire i_end = (i_reg == n_w);

    always_comb begin
        s_raddr = i_reg[AW-1:0];
        b_raddr = sj_reg[BW-1:0];
        b_we = 1'b0; b_waddr = sj_reg[BW-1:0]; b_wdata = key_reg;
        soft_in = d_x;
        dctl = '{start: 1'b0, neg: num < 0};
        unique case (st_reg)
            ST_BPWR: begin
                b_we = phase_reg || !cur_excl;
                b_waddr = m_reg[BW-1:0];
                b_wdata = phase_reg ? BP_W'(srd_reg) + BP_W'(lam_reg)
                                    : BP_W'(srd_reg) - BP_W'(lam_reg);
                if (phase_reg && cur_excl) b_we = 1'b0;
            end
            // key fetch for the next insertion
            ST_SRT0: b_raddr = si_reg[BW-1:0];
            ST_SRT1: begin
                b_raddr = BW'(sj_reg - 1'b1);
            end
            ST_SRT2: begin
                b_we = 1'b1;
                b_waddr = sj_reg[BW-1:0];
                b_wdata = (sj_reg != '0 && brd_reg < key_reg) ? brd_reg : key_reg;
            end
            ST_BIS0: b_raddr = BW'(((lo_reg + hi_reg + 1) >>> 1));
            ST_SUP0: b_raddr = lo_reg[BW-1:0];
            ST_SUP1: b_raddr = hi_reg[BW-1:0];
            ST_DIV:  dctl.start = phase_reg;
            ST_OUT:  soft_in = x_x - ACC_W'(nu_reg);
            default: ;
        endcase
    end

    logic [MW:0] mid_w;
    always_comb begin
        logic signed [MW:0] t;
        t = (lo_reg + hi_reg + 1) >>> 1;
        if (t == lo_reg) t = t + 1;
        else if (t == hi_reg) t = t - 1;
        mid_w = t;
    end

    always_ff @(posedge aclk) begin
        srd_reg <= smem[s_raddr];
        brd_reg <= bmem[b_raddr];
        if (s_acc) smem[cnt_reg[AW-1:0]] <= s_sample;
        if (b_we) bmem[b_waddr] <= b_wdata;
    end

    logic signed [BP_W+1:0] d2;
    assign d2 = 2 * (BP_W+2)'(srd_reg) - a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_LOAD; cnt_reg <= '0; excl_vld_reg <= 1'b0; excl_pos_reg <= '0;
            lam_reg <= THRESHOLD_RST[LAMBDA_W-1:0]; b_reg <= '0; m_valid <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_THRESHOLD) lam_reg <= cfg_data[LAMBDA_W-1:0];
                else if (cfg_index == REG_TARGET_SUM) b_reg <= cfg_data;
            end
            unique case (st_reg)
                ST_LOAD: if (s_acc) begin
                    if (s_excluded) begin
                        excl_vld_reg <= 1'b1; excl_pos_reg <= cnt_reg[AW-1:0];
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (fin) begin
                        i_reg <= '0; m_reg <= '0; phase_reg <= 1'b0; st_reg <= ST_BPRD;
                    end
                end
                ST_BPRD: st_reg <= i_end ? ST_SRT0 : ST_BPWR;
                ST_BPWR: begin
                    if (!cur_excl) m_reg <= m_reg + 1'b1;
                    phase_reg <= !phase_reg;
                    if (phase_reg) begin
                        i_reg <= i_reg + 1'b1; st_reg <= ST_BPRD;
                    end
                    si_reg <= MW'(1);
                end
                ST_SRT0: begin
                    // insertion sort: fetch key at si
                    if (si_reg >= m_reg) begin
                        if (m_reg == '0) begin
                            empty_reg <= 1'b1; i_reg <= '0; st_reg <= ST_OUT;
                            nu_reg <= '0;
                        end else begin
                            lo_reg <= -1; hi_reg <= (MW+1)'(m_reg);
                            its_reg <= ITW'($clog2(NB) + 1);
                            empty_reg <= 1'b0;
                            st_reg <= ST_BIS0;
                        end
                    end else begin
                        sj_reg <= si_reg; st_reg <= ST_SRT1;
                    end
                end
                ST_SRT1: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                        if (sj_reg == si_reg) key_reg <= brd_reg;
                    end else begin
                        phase_reg <= 1'b0;
                        st_reg <= ST_SRT2;
                    end
                end
                ST_SRT2: begin
                    if (sj_reg != '0 && brd_reg < key_reg) begin
                        sj_reg <= sj_reg - 1'b1; st_reg <= ST_SRT1;
                    end else begin
                        si_reg <= si_reg + 1'b1; st_reg <= ST_SRT0;
                    end
                end
                ST_BIS0: begin
                    if (hi_reg - lo_reg <= 1 || its_reg == '0) begin
                        st_reg <= ST_SUP0; phase_reg <= 1'b0;
                    end else begin
                        sj_reg <= MW'(mid_w); st_reg <= ST_BIS1; phase_reg <= 1'b0;
                    end
                end
                ST_BIS1: begin
                    if (!phase_reg) phase_reg <= 1'b1;
                    else begin
                        a_reg <= brd_reg; h_reg <= -ACC_W'(b_reg); i_reg <= '0;
                        phase_reg <= 1'b0; st_reg <= ST_BIS2;
                    end
                end
                ST_BIS2: begin
                    // elements are summed one after another through the shared soft unit
                    if (!phase_reg) phase_reg <= 1'b1;
                    else if (i_end) begin
                        if (h_reg > 0) hi_reg <= (MW+1)'(sj_reg);
                        else lo_reg <= (MW+1)'(sj_reg);
                        its_reg <= its_reg - 1'b1;
                        phase_reg <= 1'b0; st_reg <= ST_BIS0;
                    end else begin
                        if (!cur_excl) h_reg <= h_reg + soft_out;
                        i_reg <= i_reg + 1'b1; phase_reg <= 1'b0;
                    end
                end
                ST_SUP0: begin
                    if (!phase_reg) phase_reg <= 1'b1;
                    else begin
                        lo_v_reg <= brd_reg; phase_reg <= 1'b0; st_reg <= ST_SUP1;
                    end
                end
                ST_SUP1: begin
                    if (!phase_reg) phase_reg <= 1'b1;
                    else begin
                        if (lo_reg == -1)
                            a2_reg <= 2 * (BP_W+2)'(brd_reg) - WIDEN;
                        else if (hi_reg == (MW+1)'(m_reg))
                            a2_reg <= 2 * (BP_W+2)'(lo_v_reg) + WIDEN;
                        else
                            a2_reg <= (BP_W+2)'(lo_v_reg) + (BP_W+2)'(brd_reg);
                        sum_reg <= '0; sc_reg <= '0; i_reg <= '0;
                        phase_reg <= 1'b0; st_reg <= ST_SUP2;
                    end
                end
                ST_SUP2: begin
                    if (!phase_reg) phase_reg <= 1'b1;
                    else if (i_end) begin
                        if (sc_reg == '0) begin
                            empty_reg <= 1'b1; nu_reg <= '0; i_reg <= '0;
                            phase_reg <= 1'b0; st_reg <= ST_OUT;
                        end else begin
                            phase_reg <= 1'b1; st_reg <= ST_DIV;
                        end
                    end else begin
                        if (!cur_excl) begin
                            if (d2 > 2 * (BP_W+2)'(lam_x)) begin
                                sum_reg <= sum_reg + x_x - lam_x; sc_reg <= sc_reg + 1'b1;
                            end else if (d2 < -2 * (BP_W+2)'(lam_x)) begin
                                sum_reg <= sum_reg + x_x + lam_x; sc_reg <= sc_reg + 1'b1;
                            end
                        end
                        i_reg <= i_reg + 1'b1; phase_reg <= 1'b0;
                    end
                end
                ST_DIV: begin
                    phase_reg <= 1'b0;
                    if (ddone) begin
                        nu_reg <= dq; i_reg <= '0; st_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // first wait for the registered store read, then present
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b0;
                        if (phase_reg) begin
                            m_valid <= 1'b1;
                            if (empty_reg || cur_excl) m_value <= '0;
                            else if (soft_out > ACC_W'(32'sh7fffffff)) m_value <= 32'sh7fffffff;
                            else if (soft_out < -ACC_W'(33'sh080000000)) m_value <= 32'sh80000000;
                            else m_value <= soft_out[31:0];
                            m_empty_support <= empty_reg;
                            m_final_res <= (i_reg + 1'b1 == n_w);
                            phase_reg <= 1'b0;
                            i_reg <= i_reg + 1'b1;
                            if (i_reg + 1'b1 == n_w) st_reg <= ST_OUTW;
                        end else phase_reg <= 1'b1;
                    end
                end
                ST_OUTW: if (m_ready) begin
                    m_valid <= 1'b0; cnt_reg <= '0; excl_vld_reg <= 1'b0;
                    excl_pos_reg <= '0; st_reg <= ST_LOAD;
                end
                default: st_reg <= ST_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire
